FILE: rtl/frustum_box_visibility_test_defines.svh
// Assertion macros used by the checker file.
`ifndef FRUSTUM_BOX_VISIBILITY_TEST_DEFINES_SVH
`define FRUSTUM_BOX_VISIBILITY_TEST_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define FBV_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define FBV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fbv_pkg.sv
package fbv_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int FIELD_W     = 32;

  localparam int PROD_W = 2 * COORD_WIDTH;
  // Wide enough for three full products plus the shifted offset term
  localparam int ACC_W  = 2 * COORD_WIDTH + FRAC_BITS + 2;

  localparam int PLANE_COUNT  = 6;
  localparam int CORNER_COUNT = 8;
  localparam int AXES         = 3;
  localparam int COEFS        = 4;
  localparam int IDX_W        = 3;
  localparam int STEP_W       = 2;
  localparam int FACES        = 2 * AXES;

  localparam logic [IDX_W-1:0]  PLANE_LAST  = IDX_W'(PLANE_COUNT - 1);
  localparam logic [IDX_W-1:0]  CORNER_LAST = IDX_W'(CORNER_COUNT - 1);
  localparam logic [STEP_W-1:0] STEP_LAST   = STEP_W'(COEFS - 1);

  localparam int IN_TDATA_W  = 7 * FIELD_W;
  localparam int IN_TUSER_W  = 2 + IDX_W;
  localparam int OUT_TDATA_W = 8;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef enum logic [1:0] {
    OP_LOAD_PLANE  = 2'd0,
    OP_LOAD_CORNER = 2'd1,
    OP_TEST_BOX    = 2'd2
  } fbv_op_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PLANE = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_DONE  = 4'b1000
  } fbv_state_t;

  // Sign-extend a 32-bit field, then wrap to the coordinate width
  function automatic coord_t coord_in(input logic [FIELD_W-1:0] raw);
    logic signed [63:0] ext;
    ext = 64'(signed'(raw));
    return ext[COORD_WIDTH-1:0];
  endfunction

endpackage

FILE: rtl/frustum_box_visibility_test.sv
// Load transactions (plane or frustum corner) write the store and leave in_tready high.
// A box test runs on one shared multiplier, one product per cycle: a plane pass tests
// each plane against the box corners, a frustum-corner pass follows if no plane culls
// the box, and the result is then registered.
// One test at a time, in_tready low meanwhile; a result waits in the output register.
// Reset (rst_n low, synchronous): stores cleared to zero, sequencer idle, output empty.
module frustum_box_visibility_test
  import fbv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // first_x, first_y, first_z, plane_offset, box_max_x, box_max_y, box_max_z
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // operation, entry_index
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // visible, zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  fbv_state_t state_r, state_nxt;

  coord_t plane_store_r  [PLANE_COUNT][COEFS];
  coord_t corner_store_r [CORNER_COUNT][AXES];
  coord_t box_min_r [AXES];
  coord_t box_max_r [AXES];

  logic [IDX_W-1:0]       plane_r;
  logic [IDX_W-1:0]       corner_r;
  logic [STEP_W-1:0]      step_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [FACES-1:0]       beyond_r;
  logic                   result_r;
  logic                   out_tvalid_r;
  logic                   out_visible_r;

  logic [1:0]       in_op;
  logic [IDX_W-1:0] in_idx;
  coord_t           in_val [7];
  logic             in_fire;

  coord_t                   mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0]  acc_sum;
  logic                     plane_nonneg;
  logic                     corner_inside;
  logic [FACES-1:0]         beyond_now;
  logic [FACES-1:0]         beyond_acc;
  logic                     out_load;

  assign in_op   = in_tuser[1:0];
  assign in_idx  = in_tuser[IN_TUSER_W-1:2];
  assign in_fire = in_tvalid && in_tready;

  always_comb begin
    for (int k = 0; k < 7; k++) begin
      in_val[k] = coord_in(in_tdata[k*FIELD_W +: FIELD_W]);
    end
  end

  // Shared multiplier: one coefficient times one box-corner coordinate
  always_comb begin
    case (step_r)
      2'd0: begin
        mul_a = plane_store_r[plane_r][0];
        mul_b = corner_r[0] ? box_max_r[0] : box_min_r[0];
      end
      2'd1: begin
        mul_a = plane_store_r[plane_r][1];
        mul_b = corner_r[1] ? box_max_r[1] : box_min_r[1];
      end
      2'd2: begin
        mul_a = plane_store_r[plane_r][2];
        mul_b = corner_r[2] ? box_max_r[2] : box_min_r[2];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt     = mul_a * mul_b;
  assign acc_sum      = acc_r + ACC_W'(prod_r);
  assign plane_nonneg = !acc_sum[ACC_W-1];

  // Frustum corner against the box: inside test and per-face beyond flags
  always_comb begin
    corner_inside = 1'b1;
    for (int a = 0; a < AXES; a++) begin
      if (corner_store_r[corner_r][a] < box_min_r[a] ||
          corner_store_r[corner_r][a] > box_max_r[a]) begin
        corner_inside = 1'b0;
      end
      beyond_now[2*a]   = corner_store_r[corner_r][a] > box_max_r[a];
      beyond_now[2*a+1] = corner_store_r[corner_r][a] < box_min_r[a];
    end
  end

  assign beyond_acc = beyond_r & beyond_now;
  assign out_load   = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_op == OP_TEST_BOX) begin
          state_nxt = ST_PLANE;
        end
      end
      ST_PLANE: begin
        if (step_r == STEP_LAST) begin
          if (plane_nonneg && plane_r == PLANE_LAST) begin
            state_nxt = ST_CHECK;
          end else if (!plane_nonneg && corner_r == CORNER_LAST) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_CHECK: begin
        if (corner_inside || corner_r == CORNER_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Plane and corner stores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        for (int k = 0; k < COEFS; k++) begin
          plane_store_r[p][k] <= '0;
        end
      end
      for (int c = 0; c < CORNER_COUNT; c++) begin
        for (int k = 0; k < AXES; k++) begin
          corner_store_r[c][k] <= '0;
        end
      end
    end else if (in_fire) begin
      case (in_op)
        OP_LOAD_PLANE: begin
          if (in_idx <= PLANE_LAST) begin
            for (int k = 0; k < COEFS; k++) begin
              plane_store_r[in_idx][k] <= in_val[k];
            end
          end
        end
        OP_LOAD_CORNER: begin
          for (int k = 0; k < AXES; k++) begin
            corner_store_r[in_idx][k] <= in_val[k];
          end
        end
        default: ;
      endcase
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r  <= '0;
      corner_r <= '0;
      step_r   <= '0;
      beyond_r <= '0;
      result_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          plane_r  <= '0;
          corner_r <= '0;
          step_r   <= '0;
        end
        ST_PLANE: begin
          step_r <= step_r + 1'b1;
          if (step_r == STEP_LAST) begin
            if (plane_nonneg) begin
              // advance to the next plane, restart at box corner zero
              plane_r  <= plane_r + 1'b1;
              corner_r <= '0;
              beyond_r <= '1;
            end else if (corner_r == CORNER_LAST) begin
              result_r <= 1'b0;
            end else begin
              corner_r <= corner_r + 1'b1;
            end
          end
        end
        ST_CHECK: begin
          beyond_r <= beyond_acc;
          corner_r <= corner_r + 1'b1;
          if (corner_inside) begin
            result_r <= 1'b1;
          end else if (corner_r == CORNER_LAST) begin
            result_r <= ~|beyond_acc;
          end
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  // Box capture, product and accumulator registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_fire) begin
      for (int a = 0; a < AXES; a++) begin
        box_min_r[a] <= in_val[a];
        box_max_r[a] <= in_val[4+a];
      end
    end
    prod_r <= prod_nxt;
    if (state_r == ST_PLANE) begin
      if (step_r == '0) begin
        acc_r <= ACC_W'(plane_store_r[plane_r][3]) <<< FRAC_BITS;
      end else begin
        acc_r <= acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_visible_r <= result_r;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_visible_r};

endmodule

FILE: rtl/fbv_checker.sv
`include "frustum_box_visibility_test_defines.svh"

module fbv_checker
  import fbv_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TUSER_W-1:0]  in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  `FBV_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")

  `FBV_ASSERT_SAME(a_out_fill, out_tvalid, out_tdata[OUT_TDATA_W-1:1] == '0, "nonzero fill bits")

  `FBV_ASSERT_NEXT(a_test_busy, in_tvalid && in_tready && in_tuser[1:0] == OP_TEST_BOX, !in_tready, "ready after test transaction")

  `FBV_ASSERT_NEXT(a_load_ready, in_tvalid && in_tready && in_tuser[1:0] != OP_TEST_BOX, in_tready, "ready lost after load transaction")

endmodule

bind frustum_box_visibility_test fbv_checker u_fbv_checker (.*);

FILE: test/frustum_box_visibility_test_test.sv
`timescale 1ns / 100ps

module frustum_box_visibility_test_test;
  import fbv_pkg::*;

  localparam int RANDOM_ITEMS = 650;
  localparam int DRAIN_AT     = 300;
  localparam int BURST_FROM   = 400;
  localparam int BURST_TO     = 470;
  localparam int HOLD_AT      = 120;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 250;
  localparam int SUM_W        = 2 * COORD_WIDTH + FRAC_BITS + 4;
  localparam int Q            = 1 << FRAC_BITS;
  localparam int DIR_ROWS     = 25;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [FIELD_W-1:0] Q_0   = 32'h0000_0000;
  localparam logic [FIELD_W-1:0] Q_1   = 32'h0001_0000;
  localparam logic [FIELD_W-1:0] Q_M1  = 32'hFFFF_0000;
  localparam logic [FIELD_W-1:0] Q_2   = 32'h0002_0000;
  localparam logic [FIELD_W-1:0] Q_4   = 32'h0004_0000;
  localparam logic [FIELD_W-1:0] Q_5   = 32'h0005_0000;
  localparam logic [FIELD_W-1:0] Q_M5  = 32'hFFFB_0000;
  localparam logic [FIELD_W-1:0] Q_6   = 32'h0006_0000;
  localparam logic [FIELD_W-1:0] Q_8   = 32'h0008_0000;
  localparam logic [FIELD_W-1:0] Q_10  = 32'h000A_0000;
  localparam logic [FIELD_W-1:0] Q_20  = 32'h0014_0000;
  localparam logic [FIELD_W-1:0] Q_M20 = 32'hFFEC_0000;
  localparam logic [FIELD_W-1:0] Q_30  = 32'h001E_0000;
  localparam logic [FIELD_W-1:0] C_MIN = 32'h8000_0000;
  localparam logic [FIELD_W-1:0] C_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0]         op;
    logic [IDX_W-1:0]   idx;
    logic [FIELD_W-1:0] min_x;
    logic [FIELD_W-1:0] min_y;
    logic [FIELD_W-1:0] min_z;
    logic [FIELD_W-1:0] offset;
    logic [FIELD_W-1:0] max_x;
    logic [FIELD_W-1:0] max_y;
    logic [FIELD_W-1:0] max_z;
  } fbv_item_t;

  typedef enum logic [1:0] {VIS_CULLED, VIS_SHOWN, VIS_PREDICT} vis_src_t;

  typedef struct {
    fbv_item_t item;
    vis_src_t  src;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  coord_t plane_coef [PLANE_COUNT][COEFS];
  coord_t frustum_pt [CORNER_COUNT][AXES];
  bit     vis_expect_q [$];
  bit     no_idle = 1'b0;
  int     error_count = 0;
  int     vis_seen = 0;
  int     shown_count = 0;
  int     culled_count = 0;
  int     plane_loads = 0;
  int     corner_loads = 0;
  int     box_tests = 0;
  int     ignored_items = 0;

  // plane rows: a, b, c in the min fields, d in offset; corners: cube of +-5
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{OP_TEST_BOX, 3'd0, Q_M1, Q_M1, Q_M1, Q_0, Q_1, Q_1, Q_1}, VIS_SHOWN},
    '{'{OP_TEST_BOX, 3'd0, Q_1, Q_1, Q_1, Q_0, Q_2, Q_2, Q_2}, VIS_CULLED},
    '{'{OP_TEST_BOX, 3'd0, C_MIN, C_MIN, C_MIN, Q_0, C_MAX, C_MAX, C_MAX}, VIS_SHOWN},
    '{'{OP_TEST_BOX, 3'd0, Q_1, Q_1, Q_1, Q_0, Q_M1, Q_M1, Q_M1}, VIS_CULLED},
    '{'{OP_UNUSED, 3'd7, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX}, VIS_PREDICT},
    '{'{OP_LOAD_PLANE, 3'd0, Q_1, Q_0, Q_0, Q_10, C_MAX, C_MIN, C_MAX}, VIS_PREDICT},
    '{'{OP_LOAD_PLANE, 3'd1, Q_M1, Q_0, Q_0, Q_10, C_MIN, C_MAX, C_MIN}, VIS_PREDICT},
    '{'{OP_LOAD_PLANE, 3'd2, Q_0, Q_1, Q_0, Q_10, Q_0, Q_0, Q_0}, VIS_PREDICT},
    '{'{OP_LOAD_PLANE, 3'd3, Q_0, Q_M1, Q_0, Q_10, Q_0, Q_0, Q_0}, VIS_PREDICT},
    '{'{OP_LOAD_PLANE, 3'd4, Q_0, Q_0, Q_1, Q_10, Q_0, Q_0, Q_0}, VIS_PREDICT},
    '{'{OP_LOAD_PLANE, 3'd5, Q_0, Q_0, Q_M1, Q_10, Q_0, Q_0, Q_0}, VIS_PREDICT},
    '{'{OP_LOAD_PLANE, 3'd6, Q_0, Q_0, Q_0, Q_M1, Q_0, Q_0, Q_0}, VIS_PREDICT},
    '{'{OP_LOAD_CORNER, 3'd0, Q_M5, Q_M5, Q_M5, C_MAX, C_MIN, C_MIN, C_MIN}, VIS_PREDICT},
    '{'{OP_LOAD_CORNER, 3'd1, Q_5, Q_M5, Q_M5, C_MAX, C_MIN, C_MIN, C_MIN}, VIS_PREDICT},
    '{'{OP_LOAD_CORNER, 3'd2, Q_M5, Q_5, Q_M5, C_MAX, C_MIN, C_MIN, C_MIN}, VIS_PREDICT},
    '{'{OP_LOAD_CORNER, 3'd3, Q_5, Q_5, Q_M5, C_MAX, C_MIN, C_MIN, C_MIN}, VIS_PREDICT},
    '{'{OP_LOAD_CORNER, 3'd4, Q_M5, Q_M5, Q_5, C_MAX, C_MIN, C_MIN, C_MIN}, VIS_PREDICT},
    '{'{OP_LOAD_CORNER, 3'd5, Q_5, Q_M5, Q_5, C_MAX, C_MIN, C_MIN, C_MIN}, VIS_PREDICT},
    '{'{OP_LOAD_CORNER, 3'd6, Q_M5, Q_5, Q_5, C_MAX, C_MIN, C_MIN, C_MIN}, VIS_PREDICT},
    '{'{OP_LOAD_CORNER, 3'd7, Q_5, Q_5, Q_5, C_MAX, C_MIN, C_MIN, C_MIN}, VIS_PREDICT},
    '{'{OP_TEST_BOX, 3'd7, Q_20, Q_20, Q_20, C_MIN, Q_30, Q_30, Q_30}, VIS_PREDICT},
    '{'{OP_TEST_BOX, 3'd0, Q_4, Q_4, Q_4, Q_0, Q_6, Q_6, Q_6}, VIS_PREDICT},
    '{'{OP_TEST_BOX, 3'd0, Q_M1, Q_M1, Q_M1, Q_0, Q_1, Q_1, Q_1}, VIS_PREDICT},
    '{'{OP_TEST_BOX, 3'd0, Q_6, Q_M20, Q_M20, Q_0, Q_8, Q_20, Q_20}, VIS_PREDICT},
    '{'{OP_TEST_BOX, 3'd0, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX}, VIS_PREDICT}
  };

  frustum_box_visibility_test i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Exact plane value at (x, y, z, 1); only the sign matters
  function automatic bit plane_keeps(input int p, input coord_t x, input coord_t y,
                                     input coord_t z);
    logic signed [SUM_W-1:0] a, b, c, d, px, py, pz, unit, sum;
    a    = plane_coef[p][0];
    b    = plane_coef[p][1];
    c    = plane_coef[p][2];
    d    = plane_coef[p][3];
    px   = x;
    py   = y;
    pz   = z;
    unit = 1;
    unit = unit <<< FRAC_BITS;
    sum  = a * px + b * py + c * pz + d * unit;
    return !sum[SUM_W-1];
  endfunction

  function automatic bit box_shown(input coord_t lo [AXES], input coord_t hi [AXES]);
    bit     any_kept, pt_in;
    int     beyond, ax;
    coord_t v;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      any_kept = 1'b0;
      for (int c = 0; c < 8; c++)
        if (plane_keeps(p, (c & 1) != 0 ? hi[0] : lo[0], (c & 2) != 0 ? hi[1] : lo[1],
                        (c & 4) != 0 ? hi[2] : lo[2]))
          any_kept = 1'b1;
      if (!any_kept) return 1'b0;
    end
    for (int c = 0; c < CORNER_COUNT; c++) begin
      pt_in = 1'b1;
      for (int k = 0; k < AXES; k++)
        if (frustum_pt[c][k] < lo[k] || frustum_pt[c][k] > hi[k]) pt_in = 1'b0;
      if (pt_in) return 1'b1;
    end
    for (int f = 0; f < FACES; f++) begin
      ax     = f / 2;
      beyond = 0;
      for (int c = 0; c < CORNER_COUNT; c++) begin
        v = frustum_pt[c][ax];
        if ((f % 2) != 0 ? (v < lo[ax]) : (v > hi[ax])) beyond++;
      end
      if (beyond == CORNER_COUNT) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Update the stores; return 1 when the transaction yields a result
  function automatic bit apply_item(input fbv_item_t it, output bit vis);
    coord_t lo [AXES];
    coord_t hi [AXES];
    vis = 1'b0;
    case (it.op)
      OP_LOAD_PLANE: begin
        if (it.idx < PLANE_COUNT) begin
          plane_coef[it.idx][0] = it.min_x;
          plane_coef[it.idx][1] = it.min_y;
          plane_coef[it.idx][2] = it.min_z;
          plane_coef[it.idx][3] = it.offset;
        end
        return 1'b0;
      end
      OP_LOAD_CORNER: begin
        frustum_pt[it.idx][0] = it.min_x;
        frustum_pt[it.idx][1] = it.min_y;
        frustum_pt[it.idx][2] = it.min_z;
        return 1'b0;
      end
      OP_TEST_BOX: begin
        lo[0] = it.min_x;
        lo[1] = it.min_y;
        lo[2] = it.min_z;
        hi[0] = it.max_x;
        hi[1] = it.max_y;
        hi[2] = it.max_z;
        vis = box_shown(lo, hi);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [FIELD_W-1:0] rand_coord(input int span);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return C_MIN;
          1: return C_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return FIELD_W'(int'($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  function automatic fbv_item_t gen_item();
    fbv_item_t it;
    int        pick;
    // unused fields carry noise
    it.idx    = IDX_W'($urandom_range(0, 7));
    it.min_x  = $urandom;
    it.min_y  = $urandom;
    it.min_z  = $urandom;
    it.offset = $urandom;
    it.max_x  = $urandom;
    it.max_y  = $urandom;
    it.max_z  = $urandom;
    pick      = $urandom_range(0, 99);
    if (pick < 15) begin
      it.op     = OP_LOAD_PLANE;
      it.min_x  = rand_coord(Q);
      it.min_y  = rand_coord(Q);
      it.min_z  = rand_coord(Q);
      it.offset = rand_coord(32 * Q);
    end else if (pick < 35) begin
      it.op    = OP_LOAD_CORNER;
      it.min_x = rand_coord(16 * Q);
      it.min_y = rand_coord(16 * Q);
      it.min_z = rand_coord(16 * Q);
    end else if (pick < 39) begin
      it.op = OP_UNUSED;
    end else begin
      it.op    = OP_TEST_BOX;
      it.min_x = rand_coord(24 * Q);
      it.min_y = rand_coord(24 * Q);
      it.min_z = rand_coord(24 * Q);
      if ($urandom_range(0, 6) == 0) begin
        // independent max: often an inverted box
        it.max_x = rand_coord(24 * Q);
        it.max_y = rand_coord(24 * Q);
        it.max_z = rand_coord(24 * Q);
      end else begin
        it.max_x = it.min_x + FIELD_W'($urandom_range(0, 20 * Q));
        it.max_y = it.min_y + FIELD_W'($urandom_range(0, 20 * Q));
        it.max_z = it.min_z + FIELD_W'($urandom_range(0, 20 * Q));
      end
    end
    return it;
  endfunction

  task automatic send_item(input fbv_item_t it, input vis_src_t src);
    int gap;
    bit vis;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {it.max_z, it.max_y, it.max_x, it.offset, it.min_z, it.min_y, it.min_x};
    in_tuser  <= {it.idx, it.op};
    do @(posedge clk); while (!in_tready);
    if (apply_item(it, vis))
      vis_expect_q.push_back(src == VIS_PREDICT ? vis : (src == VIS_SHOWN));
    if (it.op == OP_LOAD_PLANE && it.idx < PLANE_COUNT) plane_loads++;
    else if (it.op == OP_LOAD_CORNER) corner_loads++;
    else if (it.op == OP_TEST_BOX) box_tests++;
    else ignored_items++;
  endtask

  initial begin
    int        live;
    bit        drained;
    fbv_item_t it;
    foreach (plane_coef[p, k]) plane_coef[p][k] = '0;
    foreach (frustum_pt[c, k]) frustum_pt[c][k] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].src);
    live    = 0;
    drained = 1'b0;
    while (live < RANDOM_ITEMS) begin
      it = gen_item();
      if (live == DRAIN_AT && !drained) begin
        // pause until the block has emptied
        in_tvalid <= 1'b0;
        while (vis_expect_q.size() != 0) @(posedge clk);
        drained = 1'b1;
      end
      no_idle = (live >= BURST_FROM && live < BURST_TO);
      send_item(it, VIS_PREDICT);
      if (!(it.op == OP_UNUSED || (it.op == OP_LOAD_PLANE && it.idx >= PLANE_COUNT)))
        live++;
    end
    no_idle = 1'b0;
    in_tvalid <= 1'b0;
    while (vis_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run: %0d plane loads, %0d corner loads, %0d box tests, %0d ignored transactions",
             plane_loads, corner_loads, box_tests, ignored_items);
    $display("Results checked: %0d (%0d visible, %0d culled), %0d errors",
             vis_seen, shown_count, culled_count, error_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    int stall;
    bit want;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 10);
      if (vis_seen == HOLD_AT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      vis_seen++;
      if (out_tdata[0]) shown_count++;
      else culled_count++;
      if (vis_expect_q.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("ERROR: unexpected result visible=%0b at %0t", out_tdata[0], $realtime);
      end else begin
        want = vis_expect_q.pop_front();
        if (out_tdata[0] !== want) begin
          error_count++;
          if (error_count <= 10)
            $display("ERROR: result %0d visible expected %0b got %0b at %0t",
                     vis_seen, want, out_tdata[0], $realtime);
        end
      end
    end
  end

  initial begin
    #(6_000_000);
    $display("Timeout: %0d results still pending", vis_expect_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
